// File: sv/tsta_pkg.sv
// Shared types, constants and helper functions of the tanh/sigmoid table block.
`default_nettype none
package tsta_pkg;

	localparam int unsigned TBL_LAST = 200;
	localparam logic [14:0] ONE_Q14 = 15'd16384;
	// floor(2^22 / 50), used to divide the residual numerator by 50.
	localparam logic [33:0] RECIP50 = 34'd83886;

	typedef enum logic {
		OP_TANH    = 1'b0,
		OP_SIGMOID = 1'b1
	} tsta_op_t;

	// tanh in Q2.14 at steps of 0.04.
	localparam logic [14:0] TANH_ROM [0:TBL_LAST] = '{
		0, 655, 1308, 1957, 2599, 3234, 3858, 4471, 5071, 5656,
		6225, 6777, 7311, 7827, 8323, 8799, 9255, 9691, 10107, 10503,
		10880, 11236, 11574, 11893, 12194, 12478, 12745, 12996, 13231, 13452,
		13659, 13852, 14033, 14201, 14359, 14506, 14642, 14770, 14888, 14998,
		15101, 15196, 15284, 15366, 15442, 15512, 15578, 15638, 15695, 15746,
		15795, 15839, 15880, 15919, 15954, 15987, 16017, 16045, 16071, 16094,
		16117, 16137, 16156, 16173, 16189, 16204, 16218, 16231, 16242, 16253,
		16263, 16273, 16281, 16289, 16296, 16303, 16309, 16315, 16320, 16325,
		16330, 16334, 16338, 16341, 16345, 16348, 16350, 16353, 16355, 16358,
		16360, 16361, 16363, 16365, 16366, 16368, 16369, 16370, 16371, 16372,
		16373, 16374, 16375, 16375, 16376, 16377, 16377, 16378, 16378, 16379,
		16379, 16379, 16380, 16380, 16380, 16381, 16381, 16381, 16381, 16382,
		16382, 16382, 16382, 16382, 16382, 16383, 16383, 16383, 16383, 16383,
		16383, 16383, 16383, 16383, 16383, 16383, 16383, 16383, 16383, 16384,
		16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384,
		16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384,
		16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384,
		16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384,
		16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384,
		16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384,
		16384
	};

	// Stage payloads.
	typedef struct packed {
		logic        sig;
		logic        neg;
		logic [16:0] a12;
	} tsta_s1_t;

	typedef struct packed {
		logic              sig;
		logic              neg;
		logic [7:0]        idx;
		logic signed [11:0] t;
	} tsta_s2_t;

	typedef struct packed {
		logic        sig;
		logic        neg;
		logic [14:0] y;
		logic        t_neg;
		logic [16:0] n;
		logic [10:0] q_est;
	} tsta_s3_t;

	typedef struct packed {
		logic               sig;
		logic               neg;
		logic [14:0]        y;
		logic signed [11:0] r16;
	} tsta_s4_t;

	typedef struct packed {
		logic               sig;
		logic               neg;
		logic [14:0]        y;
		logic signed [11:0] r16;
		logic [28:0]        dy28;
		logic signed [31:0] u30;
	} tsta_s5_t;

	typedef struct packed {
		logic               sig;
		logic               neg;
		logic [14:0]        y;
		logic signed [31:0] u30;
		logic signed [10:0] m;
	} tsta_s6_t;

	typedef struct packed {
		logic               sig;
		logic               neg;
		logic [14:0]        y;
		logic signed [10:0] corr;
	} tsta_s7_t;

	function automatic logic [14:0] tanh_rom(input logic [7:0] idx);
		logic [14:0] val;
		if (idx > 8'(TBL_LAST)) begin
			val = ONE_Q14;
		end else begin
			val = TANH_ROM[idx];
		end
		return val;
	endfunction

	// Arithmetic shift right by 30, rounding half away from zero.
	function automatic logic signed [43:0] shr_round30(input logic signed [43:0] v);
		logic [43:0] mag;
		logic [43:0] q;
		mag = v[43] ? 44'(-v) : 44'(v);
		q = (mag + 44'd536870912) >> 30;
		return v[43] ? -$signed(q) : $signed(q);
	endfunction

endpackage
`default_nettype wire

// File: sv/tsta_in_if.sv
// Input sample channel: valid, ready, function select and sample.
`default_nettype none
interface tsta_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [15:0] x_value;

	modport source (output valid, output op, output x_value, input ready);
	modport sink   (input valid, input op, input x_value, output ready);
endinterface
`default_nettype wire

// File: sv/tsta_out_if.sv
// Result channel: valid, ready and the Q2.14 result.
`default_nettype none
interface tsta_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] y_value;

	modport source (output valid, output y_value, input ready);
	modport sink   (input valid, input y_value, output ready);
endinterface
`default_nettype wire

// File: sv/tsta_index.sv
// Magnitude, table index and raw residual stages (s1, s2).
`default_nettype none
module tsta_index (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic               op,
	input  wire logic signed [15:0] x_value,
	output tsta_pkg::tsta_s2_t      st_s2,
	output logic                    valid_s2
);
	import tsta_pkg::*;

	logic [16:0] mag11;
	tsta_s1_t    st_in;
	tsta_s1_t    st_s1;
	logic        valid_s1;
	logic [20:0] p;
	logic [21:0] p_rnd;
	logic [9:0]  idx_raw;
	tsta_s2_t    st_next;

	// The most negative sample has magnitude 16.0, which needs the 17th bit.
	assign mag11 = x_value[15] ? (17'h10000 - {1'b0, x_value}) : {1'b0, x_value};

	always_comb begin
		st_in.sig = (op == OP_SIGMOID);
		st_in.neg = x_value[15];
		st_in.a12 = st_in.sig ? mag11 : {mag11[15:0], 1'b0};
	end

	always_comb begin
		p       = {st_s1.a12, 4'b0} + {1'b0, st_s1.a12, 3'b0} + {4'b0, st_s1.a12};
		p_rnd   = {1'b0, p} + 22'd2048;
		idx_raw = p_rnd[21:12];
		st_next.sig = st_s1.sig;
		st_next.neg = st_s1.neg;
		if (idx_raw > 10'(TBL_LAST)) begin
			// Clamped index reads 1.0, where the correction vanishes anyway.
			st_next.idx = 8'(TBL_LAST);
			st_next.t   = '0;
		end else begin
			st_next.idx = idx_raw[7:0];
			// Residual of 25*a against idx*4096 is the low field minus 2048.
			st_next.t   = $signed({~p_rnd[11], p_rnd[10:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= st_in;
			st_s2 <= st_next;
		end
	end
endmodule
`default_nettype wire

// File: sv/tsta_resid.sv
// Table read and scaled residual by division by 25 (s3, s4).
`default_nettype none
module tsta_resid (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire tsta_pkg::tsta_s2_t st_s2,
	input  wire logic               valid_s2,
	output tsta_pkg::tsta_s4_t      st_s4,
	output logic                    valid_s4
);
	import tsta_pkg::*;

	logic [11:0] t_abs;
	logic [33:0] q_prod;
	tsta_s3_t    st_next3;
	tsta_s3_t    st_s3;
	logic        valid_s3;
	logic [16:0] rem;
	logic [10:0] q;
	tsta_s4_t    st_next4;

	always_comb begin
		t_abs = st_s2.t[11] ? 12'(-st_s2.t) : 12'(st_s2.t);
		st_next3.sig   = st_s2.sig;
		st_next3.neg   = st_s2.neg;
		st_next3.y     = tanh_rom(st_s2.idx);
		st_next3.t_neg = st_s2.t[11];
		// Rounded 16*|t|/25 is floor((32*|t| + 25) / 50).
		st_next3.n     = {t_abs, 5'b0} + 17'd25;
		q_prod         = 34'(st_next3.n) * RECIP50;
		st_next3.q_est = q_prod[32:22];
	end

	always_comb begin
		// The reciprocal estimate is low by at most one.
		rem = st_s3.n - 17'(st_s3.q_est * 17'd50);
		q   = (rem >= 17'd50) ? (st_s3.q_est + 11'd1) : st_s3.q_est;
		st_next4.sig = st_s3.sig;
		st_next4.neg = st_s3.neg;
		st_next4.y   = st_s3.y;
		st_next4.r16 = st_s3.t_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s3 <= st_next3;
			st_s4 <= st_next4;
		end
	end
endmodule
`default_nettype wire

// File: sv/tsta_correct.sv
// Correction term r*(1-y^2)*(1-y*r) over three multiply stages (s5, s6, s7).
`default_nettype none
module tsta_correct (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire tsta_pkg::tsta_s4_t st_s4,
	input  wire logic               valid_s4,
	output tsta_pkg::tsta_s7_t      st_s7,
	output logic                    valid_s7
);
	import tsta_pkg::*;

	logic [29:0]        yy;
	logic signed [27:0] yr;
	tsta_s5_t           st_next5;
	tsta_s5_t           st_s5;
	logic               valid_s5;
	logic signed [43:0] p1;
	logic signed [43:0] m_full;
	tsta_s6_t           st_next6;
	tsta_s6_t           st_s6;
	logic               valid_s6;
	logic signed [43:0] p2;
	logic signed [43:0] c_full;
	tsta_s7_t           st_next7;

	always_comb begin
		yy = 30'(st_s4.y) * 30'(st_s4.y);
		yr = $signed({13'd0, st_s4.y}) * 28'(st_s4.r16);
		st_next5.sig  = st_s4.sig;
		st_next5.neg  = st_s4.neg;
		st_next5.y    = st_s4.y;
		st_next5.r16  = st_s4.r16;
		st_next5.dy28 = 29'(30'h1000_0000 - yy);
		st_next5.u30  = 32'sh4000_0000 - 32'(yr);
	end

	always_comb begin
		p1     = 44'(st_s5.r16) * $signed({15'd0, st_s5.dy28});
		m_full = shr_round30(p1);
		st_next6.sig = st_s5.sig;
		st_next6.neg = st_s5.neg;
		st_next6.y   = st_s5.y;
		st_next6.u30 = st_s5.u30;
		st_next6.m   = m_full[10:0];
	end

	always_comb begin
		p2     = 44'(st_s6.m) * 44'(st_s6.u30);
		c_full = shr_round30(p2);
		st_next7.sig  = st_s6.sig;
		st_next7.neg  = st_s6.neg;
		st_next7.y    = st_s6.y;
		st_next7.corr = c_full[10:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s5 <= st_next5;
			st_s6 <= st_next6;
			st_s7 <= st_next7;
		end
	end
endmodule
`default_nettype wire

// File: sv/tanh_sigmoid_table_approx_top.sv
// A sample enters stage s1 on transfer; its result leaves from output stage s8.
// Throughput: one sample per cycle unless stalled; the eight stages advance together.
// The pipeline holds in place while a result waits on a low ready at the output.
// The two 30-bit-scale multiplies of the correction set the stage depth.
// Reset clears every stage valid bit; no result is pending after reset.
`default_nettype none
module tanh_sigmoid_table_approx_top (
	input  wire logic clk,
	input  wire logic arst_n,
	tsta_in_if.sink   sample,
	tsta_out_if.source result
);
	import tsta_pkg::*;

	logic               en;
	tsta_s2_t           st_s2;
	logic               valid_s2;
	tsta_s4_t           st_s4;
	logic               valid_s4;
	tsta_s7_t           st_s7;
	logic               valid_s7;
	logic signed [16:0] v;
	logic [14:0]        sat;
	logic signed [15:0] s;
	logic [16:0]        sig_sum;
	logic signed [15:0] res;
	logic               valid_s8;
	logic signed [15:0] y_s8;

	// The whole pipe moves when the output stage is empty or its result transfers.
	assign en           = !valid_s8 || result.ready;
	assign sample.ready = en;

	tsta_index u_index (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sample.valid),
		.op       (sample.op),
		.x_value  (sample.x_value),
		.st_s2    (st_s2),
		.valid_s2 (valid_s2)
	);

	tsta_resid u_resid (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.st_s2    (st_s2),
		.valid_s2 (valid_s2),
		.st_s4    (st_s4),
		.valid_s4 (valid_s4)
	);

	tsta_correct u_correct (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.st_s4    (st_s4),
		.valid_s4 (valid_s4),
		.st_s7    (st_s7),
		.valid_s7 (valid_s7)
	);

	always_comb begin
		v = $signed({2'b00, st_s7.y}) + 17'(st_s7.corr);
		if (v < 0) begin
			sat = '0;
		end else if (v > $signed({2'b00, ONE_Q14})) begin
			sat = ONE_Q14;
		end else begin
			sat = v[14:0];
		end
		s = st_s7.neg ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
		// Sigmoid is one half plus half the tanh, rounded half up.
		sig_sum = 17'(ONE_Q14) + 17'(s) + 17'd1;
		res = st_s7.sig ? $signed(sig_sum[16:1]) : s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s8 <= res;
		end
	end

	assign result.valid   = valid_s8;
	assign result.y_value = y_s8;
endmodule
`default_nettype wire

// File: verif/tanh_sigmoid_table_approx_checker.sv
// Scoreboard for the tanh/sigmoid block: predicts each result and compares it on transfer.
module tanh_sigmoid_table_approx_checker
	import tsta_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tsta_in_if   sample,
	tsta_out_if  result,
	output int   fail_count,
	output int   pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [15:0] expected_y [$];

	// Shift right by 30 with rounding half away from zero.
	function automatic longint round_shr30(input longint v);
		longint q;
		if (v < 0) begin
			q = -((-v + 64'sd536870912) >>> 30);
		end else begin
			q = (v + 64'sd536870912) >>> 30;
		end
		return q;
	endfunction

	function automatic logic signed [15:0] activation_of(input tsta_op_t op,
			input logic [15:0] x);
		logic   neg;
		longint mag, a12, p, idx, num, r16, y, dy28, u30, m, v, s;
		neg = x[15];
		mag = neg ? 65536 - longint'(x) : longint'(x);
		// The magnitude is kept in units of 2^-12; sigmoid works on x/2.
		a12 = (op == OP_SIGMOID) ? mag : 2 * mag;
		p = 25 * a12;
		idx = (p + 2048) >>> 12;
		if (idx > TBL_LAST) begin
			idx = TBL_LAST;
		end
		num = 16 * (p - idx * 4096);
		if (num < 0) begin
			r16 = -((-num * 2 + 25) / 50);
		end else begin
			r16 = (num * 2 + 25) / 50;
		end
		y = longint'(TANH_ROM[int'(idx)]);
		dy28 = 64'sd268435456 - y * y;
		u30 = 64'sd1073741824 - y * r16;
		m = round_shr30(r16 * dy28);
		v = y + round_shr30(m * u30);
		if (v < 0) begin
			v = 0;
		end
		if (v > 16384) begin
			v = 16384;
		end
		s = neg ? -v : v;
		if (op == OP_SIGMOID) begin
			return 16'((16384 + s + 1) >>> 1);
		end
		return 16'(s);
	endfunction

	initial begin
		fail_count = 0;
		pending_count = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (expected_y.size() == 0) begin
					$error("y_value transfer with no result expected: actual %0d",
						result.y_value);
					fail_count = fail_count + 1;
				end else begin
					if (result.y_value !== expected_y[0]) begin
						$error("y_value mismatch: expected %0d, actual %0d",
							expected_y[0], result.y_value);
						fail_count = fail_count + 1;
					end
					void'(expected_y.pop_front());
				end
			end
			if (sample.valid && sample.ready) begin
				expected_y.push_back(activation_of(tsta_op_t'(sample.op), sample.x_value));
			end
			pending_count = expected_y.size();
		end
	end
endmodule

// File: verif/tanh_sigmoid_table_approx_top_tb.sv
// Testbench top for the tanh/sigmoid block: clock, reset, stimulus, flow control and verdict.
module tanh_sigmoid_table_approx_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tsta_pkg::*;

	localparam int HOLDOFF_CYCLES = 200;
	localparam int STALL_LIMIT    = 1000;
	localparam int DRAIN_CYCLES   = 16;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	bit   holdoff_pending;
	int   fail_count;
	int   pending_count;
	int   stall_cycles;

	tsta_in_if  sample_ch ();
	tsta_out_if result_ch ();

	tanh_sigmoid_table_approx_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	tanh_sigmoid_table_approx_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample        (sample_ch),
		.result        (result_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_sample(input tsta_op_t op, input logic [15:0] x);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.op      <= op;
		sample_ch.x_value <= x;
		do begin
			@(posedge clk);
		end while (!sample_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_count != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic run_random(input int count, input int send_pct, input int recv_pct,
			input bit with_holdoff);
		logic [15:0] x;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int i = 0; i < count; i++) begin
			if (with_holdoff && i == count / 3) begin
				holdoff_pending = 1'b1;
			end
			case ($urandom_range(3))
				0: x = 16'($urandom);
				1: x = 16'($urandom_range(8192) - 4096);
				2: x = $urandom_range(1) ? 16'($urandom_range(17000, 16000))
					: 16'(-$urandom_range(17000, 16000));
				default: x = 16'($urandom_range(65535, 32768 + 28000));
			endcase
			send_sample(tsta_op_t'($urandom_range(1)), x);
		end
	endtask

	// Result side: random stalls, plus one long hold-off whenever one is requested.
	initial begin
		forever begin
			@(negedge clk);
			if (holdoff_pending) begin
				holdoff_pending = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
			end
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] corner_x [9];
		corner_x = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
			16'd4096, 16'd16425, 16'd82};
		arst_n = 1'b0;
		stall_cycles = 0;
		holdoff_pending = 1'b0;
		send_idle_pct = 22;
		recv_idle_pct = 49;
		sample_ch.valid = 1'b0;
		sample_ch.op = OP_TANH;
		sample_ch.x_value = '0;
		result_ch.ready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Zero, smallest steps, both extremes, the clamped table end and an index boundary.
		foreach (corner_x[k]) begin
			send_sample(OP_TANH, corner_x[k]);
			send_sample(OP_SIGMOID, corner_x[k]);
		end
		wait_drained();

		run_random(200, 22, 49, 1'b1);
		wait_drained();
		run_random(200, 49, 22, 1'b0);
		wait_drained();
		run_random(200, 0, 0, 1'b1);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
